>>> src/serpentine_error_diffusion_dither_assert.svh
// Assertion macros for the serpentine error diffusion dither block.
// Each macro expands to one labeled concurrent assertion that is clocked
// on clk and disabled while rst_n is low.
`ifndef SERPENTINE_ERROR_DIFFUSION_DITHER_ASSERT_SVH
`define SERPENTINE_ERROR_DIFFUSION_DITHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEDD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SEDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sedd_pkg.sv
// ----------------------------------------------------------------------------
// sedd_pkg
// Shared constants, types and helpers of the serpentine error diffusion
// dither block.
// ----------------------------------------------------------------------------
package sedd_pkg;

    // Default values of the top-level parameters.
    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int PALETTE_SIZE_DEF = 256;
    localparam int ERROR_BITS_DEF   = 12;

    // Fixed field widths.
    localparam int CHAN_W      = 8;
    localparam int COLOR_W     = 24;
    localparam int INDEX_W     = 8;
    localparam int WIDTH_REG_W = 11;
    localparam int DIST_W      = 18;
    localparam int TAG_W       = 16;
    localparam int NUM_CHAN    = 3;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_IMAGE_WIDTH = 1'b0;
    localparam logic REG_KEY_COLOR   = 1'b1;

    localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RESET = 11'd32;
    localparam logic [COLOR_W-1:0]     KEY_COLOR_RESET   = 24'h476C6C;

    // Item function codes.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    // Diffusion weights in sixteenths of the error.
    localparam logic [3:0] WEIGHT_AHEAD  = 4'd7;
    localparam logic [3:0] WEIGHT_BEHIND = 4'd3;
    localparam logic [3:0] WEIGHT_BELOW  = 4'd5;
    localparam logic [3:0] WEIGHT_DIAG   = 4'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CUR_RD,
        ST_CUR_WAIT,
        ST_SEARCH,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_FINISH
    } ctl_state_t;

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_SCAN,
        PS_DRAIN,
        PS_FETCH,
        PS_WAIT
    } pal_state_t;

    // Error buffer updates, in the order they are applied.
    typedef enum logic [1:0] {
        OP_AHEAD_CUR,
        OP_BEHIND_NEXT,
        OP_BELOW_NEXT,
        OP_AHEAD_NEXT
    } rmw_op_t;

    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] addr;
        logic [COLOR_W-1:0] data;
    } pal_wr_t;

    typedef struct packed {
        logic              start;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } srch_req_t;

    typedef struct packed {
        logic               done;
        logic [INDEX_W-1:0] index;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } srch_rsp_t;

    // Absolute difference of two channel values.
    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

>>> src/serpentine_error_diffusion_dither.sv
// ----------------------------------------------------------------------------
// serpentine_error_diffusion_dither
// Serpentine Floyd-Steinberg dither of RGB pixels onto a loadable palette,
// with carried errors held in a tagged two-bank row memory.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-------------------------------
//  input    | in        | in_valid/in_stall  | func, entry_index, red, green,
//           |           |                    | blue, dither_enable, start_image
//  output   | out       | out_valid/out_stall| color_index, row_done
//  config   | in        | APB psel/penable   | paddr, pwdata, prdata
//
// A palette load does not stall the input. A pixel is processed by the
// palette scan, which reads one palette entry per cycle, and the input
// stalls until it is done. After reset the error memory is cleared, one
// entry a cycle, through all 2**($clog2(MAX_WIDTH+2)+1) entries (4096 at the
// default width); no item is taken during that sweep. One finished result
// waits in the output register while the next item is taken; a pixel waits
// at its end while that register holds a stalled result.
// ----------------------------------------------------------------------------
module serpentine_error_diffusion_dither #(
    parameter int MAX_WIDTH    = sedd_pkg::MAX_WIDTH_DEF,
    parameter int PALETTE_SIZE = sedd_pkg::PALETTE_SIZE_DEF,
    parameter int ERROR_BITS   = sedd_pkg::ERROR_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  logic [sedd_pkg::INDEX_W-1:0] entry_index,
    input  logic [sedd_pkg::CHAN_W-1:0]  red,
    input  logic [sedd_pkg::CHAN_W-1:0]  green,
    input  logic [sedd_pkg::CHAN_W-1:0]  blue,
    input  logic                         dither_enable,
    input  logic                         start_image,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sedd_pkg::INDEX_W-1:0] color_index,
    output logic                         row_done,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sedd_pkg::PADDR_W-1:0] paddr,
    input  logic [sedd_pkg::PDATA_W-1:0] pwdata,
    output logic [sedd_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import sedd_pkg::*;

    localparam int EB      = ERROR_BITS;
    localparam int X_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW      = X_W + 1;
    localparam int SLOT_W  = $clog2(MAX_WIDTH + 2);
    localparam int MEM_AW  = SLOT_W + 1;
    localparam int WORD_W  = TAG_W + NUM_CHAN * EB;
    localparam int SUM_W   = EB + 1;
    localparam int V_W     = EB + 2;
    localparam int E_W     = EB - 2;
    localparam int ACC_W   = EB + 2;
    localparam logic signed [ACC_W-1:0] ERR_LIM = ACC_W'((1 << (EB - 1)) - 1);
    localparam logic signed [ACC_W-1:0] ERR_NEG = -ERR_LIM;

    // Configuration registers.
    logic [WIDTH_REG_W-1:0] image_width_reg;
    logic [COLOR_W-1:0]     key_color_reg;

    // Position state.
    logic [X_W-1:0]   col_reg;
    logic             odd_reg;
    logic [TAG_W-1:0] row_reg;

    // Per-pixel working registers.
    ctl_state_t        state_reg, state_next;
    rmw_op_t           op_reg;
    logic [X_W-1:0]    x_reg;
    logic              pix_odd_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic              plain_reg;
    logic              last_reg;
    logic [CHAN_W-1:0] orig_reg [NUM_CHAN];
    logic signed [SUM_W-1:0] sum_reg [NUM_CHAN];
    logic signed [E_W-1:0]   e_reg [NUM_CHAN];
    logic [INDEX_W-1:0] k_reg;

    // Output register.
    logic               out_valid_reg;
    logic [INDEX_W-1:0] color_index_reg;
    logic               row_done_reg;

    // Accept-time position arithmetic.
    logic             in_xfer, pix_xfer;
    logic [WW-1:0]    w_eff, pos_ext, pos_inc;
    logic [X_W-1:0]   col_eff, x_val;
    logic             odd_eff, done_val;
    logic [TAG_W-1:0] row_eff;

    // Memory and search signals.
    logic              mem_busy, mem_rd_en, mem_wr_en;
    logic [MEM_AW-1:0] mem_rd_addr, mem_wr_addr;
    logic [WORD_W-1:0] mem_rd_data, mem_wr_data;
    logic [SLOT_W-1:0] slot_lo, slot_mid, slot_hi, slot_ahead, slot_behind;
    logic [SLOT_W-1:0] rmw_slot;
    logic [TAG_W-1:0]  tag_next_row, rmw_tag;
    logic [3:0]        rmw_weight;
    logic              cur_hit, rmw_hit, out_free, cfg_wr;
    logic [CHAN_W-1:0] target [NUM_CHAN];
    logic signed [SUM_W-1:0] sum_val [NUM_CHAN];
    logic signed [E_W-1:0]   e_val [NUM_CHAN];
    logic signed [EB-1:0]    upd_val [NUM_CHAN];
    pal_wr_t   pal_wr;
    srch_req_t srch_req;
    srch_rsp_t srch_rsp;

    assign in_xfer  = in_valid && !in_stall;
    assign pix_xfer = in_xfer && (func == FUNC_PIXEL);
    assign in_stall = (state_reg != ST_IDLE) || mem_busy;
    assign out_free = !out_valid_reg || !out_stall;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_IMAGE_WIDTH: prdata = PDATA_W'(image_width_reg);
            REG_KEY_COLOR:   prdata = PDATA_W'(key_color_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= IMAGE_WIDTH_RESET;
            key_color_reg   <= KEY_COLOR_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH: image_width_reg <= pwdata[WIDTH_REG_W-1:0];
                REG_KEY_COLOR:   key_color_reg   <= pwdata[COLOR_W-1:0];
                default:         ;
            endcase
        end
    end

    // Effective width, column and row of the pixel being taken.
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(image_width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(image_width_reg);
        end
        col_eff = start_image ? '0 : col_reg;
        odd_eff = start_image ? 1'b0 : odd_reg;
        row_eff = start_image ? (row_reg + TAG_W'(2)) : row_reg;
        pos_ext = ({1'b0, col_eff} >= w_eff) ? (w_eff - WW'(1)) : {1'b0, col_eff};
        x_val   = odd_eff ? X_W'(w_eff - WW'(1) - pos_ext) : pos_ext[X_W-1:0];
        pos_inc = pos_ext + WW'(1);
        done_val = (pos_inc >= w_eff);
    end

    // Palette load port.
    always_comb
    begin
        pal_wr.en   = in_xfer && (func == FUNC_LOAD) && (32'(entry_index) < PALETTE_SIZE);
        pal_wr.addr = entry_index;
        pal_wr.data = {red, green, blue};
    end

    // Slot arithmetic: slot c+1 belongs to column c.
    always_comb
    begin
        slot_lo      = SLOT_W'(x_reg);
        slot_mid     = SLOT_W'(x_reg) + SLOT_W'(1);
        slot_hi      = SLOT_W'(x_reg) + SLOT_W'(2);
        slot_ahead   = pix_odd_reg ? slot_lo : slot_hi;
        slot_behind  = pix_odd_reg ? slot_hi : slot_lo;
        tag_next_row = tag_reg + TAG_W'(1);
        unique case (op_reg)
            OP_AHEAD_CUR:
            begin
                rmw_slot   = slot_ahead;
                rmw_tag    = tag_reg;
                rmw_weight = WEIGHT_AHEAD;
            end
            OP_BEHIND_NEXT:
            begin
                rmw_slot   = slot_behind;
                rmw_tag    = tag_next_row;
                rmw_weight = WEIGHT_BEHIND;
            end
            OP_BELOW_NEXT:
            begin
                rmw_slot   = slot_mid;
                rmw_tag    = tag_next_row;
                rmw_weight = WEIGHT_BELOW;
            end
            OP_AHEAD_NEXT:
            begin
                rmw_slot   = slot_ahead;
                rmw_tag    = tag_next_row;
                rmw_weight = WEIGHT_DIAG;
            end
            default:
            begin
                rmw_slot   = slot_ahead;
                rmw_tag    = tag_reg;
                rmw_weight = WEIGHT_AHEAD;
            end
        endcase
    end

    // An entry counts only when its tag names the row it is read for.
    assign cur_hit = (mem_rd_data[WORD_W-1 -: TAG_W] == tag_reg);
    assign rmw_hit = (mem_rd_data[WORD_W-1 -: TAG_W] == rmw_tag);

    // Carried error added to the pixel, clamped, and the match target (the pixel itself when plain).
    always_comb
    begin
        logic signed [EB-1:0] err;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            err = cur_hit ? $signed(mem_rd_data[(NUM_CHAN-c)*EB-1 -: EB]) : '0;
            sum_val[c] = $signed(SUM_W'(orig_reg[c])) + SUM_W'(err);
            if (sum_val[c][SUM_W-1])
            begin
                target[c] = '0;
            end
            else if (sum_val[c] > $signed(SUM_W'(255)))
            begin
                target[c] = '1;
            end
            else
            begin
                target[c] = sum_val[c][CHAN_W-1:0];
            end
            if (plain_reg)
            begin
                target[c] = orig_reg[c];
            end
        end
    end

    // Quantization error (sum - palette + 8) / 16, rounded toward zero.
    always_comb
    begin
        logic [CHAN_W-1:0] pal [NUM_CHAN];
        logic signed [V_W-1:0] v, vb;
        pal[0] = srch_rsp.red;
        pal[1] = srch_rsp.green;
        pal[2] = srch_rsp.blue;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            v  = V_W'(sum_reg[c]) - V_W'({1'b0, pal[c]}) + V_W'(8);
            vb = v[V_W-1] ? (v + V_W'(15)) : v;
            vb = vb >>> 4;
            e_val[c] = vb[E_W-1:0];
        end
    end

    // Weighted error added to the stored entry, saturated.
    always_comb
    begin
        logic signed [EB-1:0]    old;
        logic signed [ACC_W-1:0] delta, acc;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            old   = rmw_hit ? $signed(mem_rd_data[(NUM_CHAN-c)*EB-1 -: EB]) : '0;
            delta = ACC_W'(e_reg[c]) * $signed(ACC_W'(rmw_weight));
            acc   = ACC_W'(old) + delta;
            if (acc > ERR_LIM)
            begin
                upd_val[c] = ERR_LIM[EB-1:0];
            end
            else if (acc < ERR_NEG)
            begin
                upd_val[c] = ERR_NEG[EB-1:0];
            end
            else
            begin
                upd_val[c] = acc[EB-1:0];
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix_xfer)
                begin
                    state_next = ST_CUR_RD;
                end
            end
            ST_CUR_RD:
            begin
                state_next = ST_CUR_WAIT;
            end
            ST_CUR_WAIT:
            begin
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (srch_rsp.done)
                begin
                    state_next = ST_RMW_RD;
                end
            end
            ST_RMW_RD:
            begin
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR:
            begin
                state_next = (op_reg == OP_AHEAD_NEXT) ? ST_FINISH : ST_RMW_RD;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: memory ports and search request.
    always_comb
    begin
        mem_rd_en   = (state_reg == ST_CUR_RD) || (state_reg == ST_RMW_RD);
        mem_rd_addr = (state_reg == ST_CUR_RD) ? {tag_reg[0], slot_mid}
                                               : {rmw_tag[0], rmw_slot};
        mem_wr_en   = (state_reg == ST_RMW_WR);
        mem_wr_addr = {rmw_tag[0], rmw_slot};
        mem_wr_data = {rmw_tag, upd_val[0], upd_val[1], upd_val[2]};
        srch_req.start = (state_reg == ST_CUR_WAIT);
        srch_req.red   = target[0];
        srch_req.green = target[1];
        srch_req.blue  = target[2];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_AHEAD_CUR;
            col_reg       <= '0;
            odd_reg       <= 1'b0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SEARCH)
            begin
                op_reg <= OP_AHEAD_CUR;
            end
            else if (state_reg == ST_RMW_WR)
            begin
                op_reg <= rmw_op_t'(2'(op_reg + 2'd1));
            end
            if (pix_xfer)
            begin
                col_reg <= done_val ? '0 : pos_inc[X_W-1:0];
                odd_reg <= done_val ? !odd_eff : odd_eff;
                row_reg <= done_val ? (row_eff + TAG_W'(1)) : row_eff;
            end
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Per-pixel payload registers.
    always_ff @(posedge clk)
    begin
        if (pix_xfer)
        begin
            x_reg       <= x_val;
            pix_odd_reg <= odd_eff;
            tag_reg     <= row_eff;
            last_reg    <= done_val;
            plain_reg   <= !dither_enable || ({red, green, blue} == key_color_reg);
            orig_reg[0] <= red;
            orig_reg[1] <= green;
            orig_reg[2] <= blue;
        end
        if (state_reg == ST_CUR_WAIT)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                sum_reg[c] <= sum_val[c];
            end
        end
        if (state_reg == ST_SEARCH && srch_rsp.done)
        begin
            k_reg <= srch_rsp.index;
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                e_reg[c] <= e_val[c];
            end
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            color_index_reg <= k_reg;
            row_done_reg    <= last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign color_index = color_index_reg;
    assign row_done    = row_done_reg;

    // Palette memory and nearest search.
    sedd_palette #(
        .PALETTE_SIZE(PALETTE_SIZE)
    ) u_palette (
        .clk  (clk),
        .rst_n(rst_n),
        .wr   (pal_wr),
        .req  (srch_req),
        .rsp  (srch_rsp)
    );

    // Two banks of carried errors, selected by row parity.
    sedd_err_mem #(
        .ADDR_W(MEM_AW),
        .DATA_W(WORD_W)
    ) u_err_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (mem_rd_en),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data),
        .busy   (mem_busy)
    );

endmodule

>>> src/sedd_palette.sv
// ----------------------------------------------------------------------------
// sedd_palette
// Palette memory with a pipelined nearest-color scan, one entry per cycle,
// followed by a read of the winning entry.
// ----------------------------------------------------------------------------
module sedd_palette #(
    parameter int PALETTE_SIZE = sedd_pkg::PALETTE_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sedd_pkg::pal_wr_t   wr,
    input  sedd_pkg::srch_req_t req,
    output sedd_pkg::srch_rsp_t rsp
);
    import sedd_pkg::*;

    localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_SIZE - 1);

    logic [COLOR_W-1:0] mem [PALETTE_SIZE];
    logic [COLOR_W-1:0] rd_q;
    logic [IDX_W-1:0]   rd_addr;

    pal_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              s1_valid_reg, s2_valid_reg;
    logic [IDX_W-1:0]  s1_idx_reg, s2_idx_reg;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [DIST_W-1:0] best_d_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [CHAN_W-1:0] tgt_red_reg, tgt_green_reg, tgt_blue_reg;
    logic              issue;

    // Palette storage: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[IDX_W-1:0]] <= wr.data;
        end
        rd_q <= mem[rd_addr];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            PS_IDLE:
            begin
                if (req.start)
                begin
                    state_next = PS_SCAN;
                end
            end
            PS_SCAN:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = PS_DRAIN;
                end
            end
            PS_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = PS_FETCH;
                end
            end
            PS_FETCH:
            begin
                state_next = PS_WAIT;
            end
            PS_WAIT:
            begin
                state_next = PS_IDLE;
            end
            default:
            begin
                state_next = PS_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        issue    = (state_reg == PS_SCAN);
        rd_addr  = issue ? cnt_reg : best_idx_reg;
        cnt_next = issue ? (cnt_reg + IDX_W'(1)) : '0;
        rsp.done  = (state_reg == PS_WAIT);
        rsp.index = INDEX_W'(best_idx_reg);
        rsp.red   = rd_q[23:16];
        rsp.green = rd_q[15:8];
        rsp.blue  = rd_q[7:0];
    end

    // Squared RGB distance of the entry just read.
    always_comb
    begin
        logic [CHAN_W-1:0] d_r, d_g, d_b;
        logic [2*CHAN_W-1:0] q_r, q_g, q_b;
        d_r = abs_diff(rd_q[23:16], tgt_red_reg);
        d_g = abs_diff(rd_q[15:8], tgt_green_reg);
        d_b = abs_diff(rd_q[7:0], tgt_blue_reg);
        q_r = d_r * d_r;
        q_g = d_g * d_g;
        q_b = d_b * d_b;
        dist_next = DIST_W'(q_r) + DIST_W'(q_g) + DIST_W'(q_b);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= PS_IDLE;
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Scan pipeline and running minimum; strict compare keeps the lowest index.
    always_ff @(posedge clk)
    begin
        s1_idx_reg <= cnt_reg;
        s2_idx_reg <= s1_idx_reg;
        dist_reg   <= dist_next;
        if (state_reg == PS_IDLE && req.start)
        begin
            tgt_red_reg   <= req.red;
            tgt_green_reg <= req.green;
            tgt_blue_reg  <= req.blue;
            best_d_reg    <= '1;
            best_idx_reg  <= '0;
        end
        else if (s2_valid_reg && (dist_reg < best_d_reg))
        begin
            best_d_reg   <= dist_reg;
            best_idx_reg <= s2_idx_reg;
        end
    end

endmodule

>>> src/sedd_err_mem.sv
// ----------------------------------------------------------------------------
// sedd_err_mem
// Error row memory: one write port, one registered read port, and a
// clearing sweep that writes zero to every entry after reset.
// ----------------------------------------------------------------------------
module sedd_err_mem #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 52
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic              busy
);
    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [DATA_W-1:0] mem_wd;

    // The sweep owns the write port until it has gone through every entry.
    always_comb
    begin
        mem_we = clr_busy_reg || wr_en;
        mem_wa = clr_busy_reg ? clr_addr_reg : wr_addr;
        mem_wd = clr_busy_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    // Clearing sweep after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == '1)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign busy = clr_busy_reg;

endmodule

>>> src/sedd_checker.sv
// ----------------------------------------------------------------------------
// sedd_checker
// Port-level checks of the serpentine error diffusion dither block,
// attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
`include "serpentine_error_diffusion_dither_assert.svh"

module sedd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         func,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [sedd_pkg::INDEX_W-1:0] color_index,
    input logic                         row_done,
    input logic                         psel,
    input logic                         penable,
    input logic                         pready
);
    import sedd_pkg::*;

    // A stalled result holds.
    `SEDD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(color_index) && $stable(row_done), "stalled result changed")

    // A pixel transfer starts a multi-cycle job.
    `SEDD_ASSERT_NEXT(a_pixel_busy, in_valid && !in_stall && func == FUNC_PIXEL, in_stall, "input open after pixel transfer")

    // A palette load finishes in its own cycle.
    `SEDD_ASSERT_NEXT(a_load_quick, in_valid && !in_stall && func == FUNC_LOAD, !in_stall, "input stalled after palette load")

    // The configuration port never inserts wait states.
    `SEDD_ASSERT_IMPLY(a_cfg_ready, psel && penable, pready, "configuration access not ready")

endmodule

bind serpentine_error_diffusion_dither sedd_checker u_checker (.*);
